>>> src/prfac_pkg.sv
`timescale 1ns / 1ps

package prfac_pkg;

   localparam int NUM_WIDTH_DEF = 31;
   localparam int EXP_W         = 5;
   localparam int MAX_RESULTS   = 9;
   localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

   // Sequencer program counter and step addresses.
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] S_LOAD      = 4'd0;
   localparam logic [PC_W-1:0] S_DIV       = 4'd1;
   localparam logic [PC_W-1:0] S_TEST      = 4'd2;
   localparam logic [PC_W-1:0] S_REDUCE    = 4'd3;
   localparam logic [PC_W-1:0] S_REDIV     = 4'd4;
   localparam logic [PC_W-1:0] S_PUSH      = 4'd5;
   localparam logic [PC_W-1:0] S_NEXT      = 4'd6;
   localparam logic [PC_W-1:0] S_TAIL      = 4'd7;
   localparam logic [PC_W-1:0] S_PUSH_REM  = 4'd8;
   localparam logic [PC_W-1:0] S_FLUSH     = 4'd9;
   localparam logic [PC_W-1:0] S_TRIV      = 4'd10;

   // Datapath operations of one control word.
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP       = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD      = 3'd1;
   localparam logic [OP_W-1:0] OP_DIV       = 3'd2;
   localparam logic [OP_W-1:0] OP_REDUCE    = 3'd3;
   localparam logic [OP_W-1:0] OP_PUSH      = 3'd4;
   localparam logic [OP_W-1:0] OP_PUSH_REM  = 3'd5;
   localparam logic [OP_W-1:0] OP_INC_D     = 3'd6;
   localparam logic [OP_W-1:0] OP_EMIT      = 3'd7;

   // Jump conditions, evaluated when the step's operation completes.
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] C_NEVER   = 3'd0;
   localparam logic [COND_W-1:0] C_ALWAYS  = 3'd1;
   localparam logic [COND_W-1:0] C_NUM_LT2 = 3'd2;
   localparam logic [COND_W-1:0] C_D_GT_Q  = 3'd3;
   localparam logic [COND_W-1:0] C_R_NZ    = 3'd4;
   localparam logic [COND_W-1:0] C_R_Z     = 3'd5;
   localparam logic [COND_W-1:0] C_K_FULL  = 3'd6;
   localparam logic [COND_W-1:0] C_REM_LE1 = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              zero;    // emit the empty result instead of the pending one
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
   } ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic ctrl_type ucode(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = '{op: OP_NOP, zero: 1'b0, cond: C_ALWAYS, target: S_LOAD};
      unique case (pc)
         S_LOAD:     w = '{op: OP_LOAD,     zero: 1'b0, cond: C_NUM_LT2, target: S_TRIV};
         S_DIV:      w = '{op: OP_DIV,      zero: 1'b0, cond: C_D_GT_Q,  target: S_TAIL};
         S_TEST:     w = '{op: OP_NOP,      zero: 1'b0, cond: C_R_NZ,    target: S_NEXT};
         S_REDUCE:   w = '{op: OP_REDUCE,   zero: 1'b0, cond: C_NEVER,   target: S_LOAD};
         S_REDIV:    w = '{op: OP_DIV,      zero: 1'b0, cond: C_R_Z,     target: S_REDUCE};
         S_PUSH:     w = '{op: OP_PUSH,     zero: 1'b0, cond: C_K_FULL,  target: S_FLUSH};
         S_NEXT:     w = '{op: OP_INC_D,    zero: 1'b0, cond: C_ALWAYS,  target: S_DIV};
         S_TAIL:     w = '{op: OP_NOP,      zero: 1'b0, cond: C_REM_LE1, target: S_FLUSH};
         S_PUSH_REM: w = '{op: OP_PUSH_REM, zero: 1'b0, cond: C_NEVER,   target: S_LOAD};
         S_FLUSH:    w = '{op: OP_EMIT,     zero: 1'b0, cond: C_ALWAYS,  target: S_LOAD};
         S_TRIV:     w = '{op: OP_EMIT,     zero: 1'b1, cond: C_ALWAYS,  target: S_LOAD};
         default:    w = '{op: OP_NOP,      zero: 1'b0, cond: C_ALWAYS,  target: S_LOAD};
      endcase
      return w;
   endfunction

endpackage

>>> src/prfac_div.sv
`timescale 1ns / 1ps

module prfac_div
   import prfac_pkg::*;
#(
   parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] dividend,
   input  logic [NUM_WIDTH-1:0] divisor,
   output logic [NUM_WIDTH-1:0] quotient,
   output logic [NUM_WIDTH-1:0] remainder,
   output div_status_type       status
);

   localparam int CW = $clog2(NUM_WIDTH + 1);

   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [NUM_WIDTH-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [NUM_WIDTH:0]   shifted;
   logic [NUM_WIDTH:0]   diff;
   logic                 ge;

   // Restoring division, one quotient bit per cycle.
   assign shifted = {acc_ff, quo_ff[NUM_WIDTH-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(NUM_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = ge ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
         quo_in = {quo_ff[NUM_WIDTH-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign remainder   = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> src/prime_factorization.sv
`timescale 1ns / 1ps

// Channel   Dir  Ports                                              Flow
// req       in   req_valid, req_stall, req_number                   one value to factor
// rsp       out  rsp_valid, rsp_stall, rsp_prime_factor,            one beat per distinct
//                rsp_exponent, rsp_has_factor, rsp_last             prime, last flags the end
//
// A divisor that does not divide takes a divide step plus one step each to test and
// advance; divisors are 2, then odd values up to the square root of the remainder.
// A new value is taken only at the load step, once the last beat of the previous one is emitted.
// Reset is synchronous and returns the sequencer to its load step; no clearing pass.
// A stall on rsp holds the sequencer only at a step that must hand over a beat.

module prime_factorization
   import prfac_pkg::*;
#(
   parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [NUM_WIDTH-1:0] req_number,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [NUM_WIDTH-1:0] rsp_prime_factor,
   output logic [EXP_W-1:0]     rsp_exponent,
   output logic                 rsp_has_factor,
   output logic                 rsp_last
);

   ctrl_type ctrl;

   logic [PC_W-1:0]      pc_ff, pc_in;
   logic [NUM_WIDTH-1:0] rem_ff, rem_in;
   logic [NUM_WIDTH-1:0] d_ff, d_in;
   logic [EXP_W-1:0]     exp_ff, exp_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] pend_prime_ff, pend_prime_in;
   logic [EXP_W-1:0]     pend_exp_ff, pend_exp_in;
   logic                 pend_v_ff, pend_v_in;
   logic                 div_wait_ff, div_wait_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NUM_WIDTH-1:0] rsp_prime_ff, rsp_prime_in;
   logic [EXP_W-1:0]     rsp_exp_ff, rsp_exp_in;
   logic                 rsp_has_ff, rsp_has_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 div_start;
   logic [NUM_WIDTH-1:0] div_q;
   logic [NUM_WIDTH-1:0] div_r;
   div_status_type       div_stat;

   logic out_free;
   logic step_done;
   logic cond_true;
   logic emit;

   assign ctrl      = ucode(pc_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign div_start = (ctrl.op == OP_DIV) && !div_wait_ff;
   assign req_stall = (pc_ff != S_LOAD);

   prfac_div #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rem_ff),
      .divisor   (d_ff),
      .quotient  (div_q),
      .remainder (div_r),
      .status    (div_stat)
   );

   always_comb begin
      unique case (ctrl.op)
         OP_LOAD:     step_done = req_valid;
         OP_DIV:      step_done = div_stat.done;
         OP_PUSH,
         OP_PUSH_REM: step_done = !pend_v_ff || out_free;
         OP_EMIT:     step_done = out_free;
         default:     step_done = 1'b1;
      endcase
   end

   always_comb begin
      unique case (ctrl.cond)
         C_NEVER:   cond_true = 1'b0;
         C_ALWAYS:  cond_true = 1'b1;
         C_NUM_LT2: cond_true = req_number < NUM_WIDTH'(2);
         C_D_GT_Q:  cond_true = d_ff > div_q;
         C_R_NZ:    cond_true = div_r != '0;
         C_R_Z:     cond_true = div_r == '0;
         C_K_FULL:  cond_true = cnt_ff == CNT_W'(MAX_RESULTS - 1);
         C_REM_LE1: cond_true = rem_ff <= NUM_WIDTH'(1);
         default:   cond_true = 1'b0;
      endcase
   end

   assign pc_in = !step_done ? pc_ff : (cond_true ? ctrl.target : pc_ff + PC_W'(1));

   always_comb begin
      div_wait_in = div_wait_ff;
      if (div_start) begin
         div_wait_in = 1'b1;
      end else if (div_stat.done) begin
         div_wait_in = 1'b0;
      end
   end

   // A found prime is held as pending until the next one or the end of the search
   // shows whether it is the final beat.
   always_comb begin
      rem_in        = rem_ff;
      d_in          = d_ff;
      exp_in        = exp_ff;
      cnt_in        = cnt_ff;
      pend_prime_in = pend_prime_ff;
      pend_exp_in   = pend_exp_ff;
      pend_v_in     = pend_v_ff;
      emit          = 1'b0;
      rsp_prime_in  = pend_prime_ff;
      rsp_exp_in    = pend_exp_ff;
      rsp_has_in    = 1'b1;
      rsp_last_in   = 1'b0;
      if (step_done) begin
         unique case (ctrl.op)
            OP_LOAD: begin
               rem_in    = req_number;
               d_in      = NUM_WIDTH'(2);
               exp_in    = '0;
               cnt_in    = '0;
               pend_v_in = 1'b0;
            end
            OP_REDUCE: begin
               rem_in = div_q;
               if (exp_ff != {EXP_W{1'b1}}) begin
                  exp_in = exp_ff + EXP_W'(1);
               end
            end
            OP_PUSH,
            OP_PUSH_REM: begin
               emit          = pend_v_ff;
               pend_prime_in = (ctrl.op == OP_PUSH_REM) ? rem_ff : d_ff;
               pend_exp_in   = (ctrl.op == OP_PUSH_REM) ? EXP_W'(1) : exp_ff;
               pend_v_in     = 1'b1;
               cnt_in        = cnt_ff + CNT_W'(1);
               exp_in        = '0;
            end
            OP_INC_D: begin
               // Past 2 only odd divisors can still divide the remainder.
               d_in = (d_ff == NUM_WIDTH'(2)) ? NUM_WIDTH'(3) : d_ff + NUM_WIDTH'(2);
            end
            OP_EMIT: begin
               emit        = 1'b1;
               rsp_last_in = 1'b1;
               if (ctrl.zero) begin
                  rsp_prime_in = '0;
                  rsp_exp_in   = '0;
                  rsp_has_in   = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      d_ff          <= d_in;
      exp_ff        <= exp_in;
      cnt_ff        <= cnt_in;
      pend_prime_ff <= pend_prime_in;
      pend_exp_ff   <= pend_exp_in;
      if (emit) begin
         rsp_prime_ff <= rsp_prime_in;
         rsp_exp_ff   <= rsp_exp_in;
         rsp_has_ff   <= rsp_has_in;
         rsp_last_ff  <= rsp_last_in;
      end
      if (reset) begin
         pc_ff        <= S_LOAD;
         pend_v_ff    <= 1'b0;
         div_wait_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         pend_v_ff    <= pend_v_in;
         div_wait_ff  <= div_wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prime_factor = rsp_prime_ff;
   assign rsp_exponent     = rsp_exp_ff;
   assign rsp_has_factor   = rsp_has_ff;
   assign rsp_last         = rsp_last_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> div_wait_ff)
      else $error("divider finished without a pending request");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= S_TRIV)
      else $error("sequencer left its program");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_has_ff |-> rsp_last_ff)
      else $error("empty result not marked last");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      pc_ff != S_LOAD |-> cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("result count beyond limit");

endmodule

>>> test/prime_factorization_tb.sv
`timescale 1ns / 1ps

module prime_factorization_tb;
   import prfac_pkg::*;

   localparam int NW = NUM_WIDTH_DEF;
   localparam longint unsigned NUM_MAX = (64'd1 << NW) - 1;
   localparam int unsigned EXP_SAT = (1 << EXP_W) - 1;

   typedef struct packed {
      logic [NW-1:0]    prime;
      logic [EXP_W-1:0] exponent;
      logic             has_factor;
      logic             last;
   } factor_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [NW-1:0]    req_number = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [NW-1:0]    rsp_prime_factor;
   logic [EXP_W-1:0] rsp_exponent;
   logic             rsp_has_factor;
   logic             rsp_last;

   logic [NW-1:0] numbers_q[$];
   factor_type    factors_q[$];
   int unsigned   offered = 0;
   int unsigned   taken = 0;
   int unsigned   in_gap = 0;
   int unsigned   out_stall = 0;
   int unsigned   errors = 0;

   prime_factorization #(
      .NUM_WIDTH(NW)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_number      (req_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_factor(rsp_prime_factor),
      .rsp_exponent    (rsp_exponent),
      .rsp_has_factor  (rsp_has_factor),
      .rsp_last        (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly no idling, sometimes a short pause, rarely a long one.
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 60);
   endfunction

   // Trial division on the masked value; appends one expected beat per distinct prime, or one empty beat for 0 and 1.
   function automatic void factorize(input logic [NW-1:0] value);
      factor_type      found[MAX_RESULTS];
      longint unsigned rem;
      longint unsigned d;
      int unsigned     e;
      int unsigned     k;
      rem = 64'(value);
      d = 2;
      k = 0;
      if (rem < 2) begin
         factors_q.push_back('{prime: '0, exponent: '0, has_factor: 1'b0, last: 1'b1});
         return;
      end
      while (d <= rem / d && k < MAX_RESULTS) begin
         if (rem % d == 0) begin
            e = 0;
            while (rem % d == 0) begin
               rem = rem / d;
               e++;
            end
            if (e > EXP_SAT) e = EXP_SAT;
            found[k] = '{prime: d[NW-1:0], exponent: e[EXP_W-1:0], has_factor: 1'b1,
                         last: 1'b0};
            k++;
         end
         d++;
      end
      // Whatever survives the search is itself prime.
      if (rem > 1 && k < MAX_RESULTS) begin
         found[k] = '{prime: rem[NW-1:0], exponent: EXP_W'(1), has_factor: 1'b1,
                      last: 1'b0};
         k++;
      end
      found[k-1].last = 1'b1;
      for (int i = 0; i < k; i++) factors_q.push_back(found[i]);
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         // taken == offered means the last offered beat has gone, or none is out.
         if (taken == offered) begin
            if (in_gap != 0) begin
               req_valid <= 1'b0;
               in_gap <= in_gap - 1;
            end else if (numbers_q.size() != 0) begin
               req_number <= numbers_q.pop_front();
               req_valid <= 1'b1;
               offered <= offered + 1;
               in_gap <= idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (out_stall != 0) begin
            rsp_stall <= 1'b1;
            out_stall <= out_stall - 1;
         end else begin
            rsp_stall <= 1'b0;
            out_stall <= idle_len();
         end
      end
   end

   // Results are checked before new inputs are predicted, so one edge carrying both is safe.
   always @(posedge clock) begin : monitor
      factor_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (factors_q.size() == 0) begin
               report_mismatch("beat with nothing expected, prime_factor",
                               64'(rsp_prime_factor), 64'd0);
            end else begin
               want = factors_q.pop_front();
               if (rsp_prime_factor !== want.prime)
                  report_mismatch("prime_factor", 64'(rsp_prime_factor), 64'(want.prime));
               if (rsp_exponent !== want.exponent)
                  report_mismatch("exponent", 64'(rsp_exponent), 64'(want.exponent));
               if (rsp_has_factor !== want.has_factor)
                  report_mismatch("has_factor", 64'(rsp_has_factor), 64'(want.has_factor));
               if (rsp_last !== want.last)
                  report_mismatch("last", 64'(rsp_last), 64'(want.last));
            end
         end
         if (req_valid && !req_stall) begin
            factorize(req_number);
            taken <= taken + 1;
         end
      end
   end

   initial begin
      longint unsigned v;
      longint unsigned p;
      int unsigned     r;
      // Trivial inputs, small primes and powers, nine distinct primes, the largest
      // exponent, all ones (a large prime) and its lower neighbour.
      numbers_q = {31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd6, 31'd9, 31'd12, 31'd30, 31'd97,
                   31'd9409, 31'd65521, 31'd65536, 31'd223092870, 31'd1073741823,
                   31'd1073741824, 31'd1162261467, 31'd2147483646, 31'd2147483647};
      for (int i = 0; i < 80; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            // Smooth numbers reach the high bits yet finish quickly.
            v = 1;
            repeat ($urandom_range(1, 30)) begin
               p = 64'($urandom_range(2, 97));
               if (v * p <= NUM_MAX) v = v * p;
            end
         end else if (r < 70) begin
            v = 64'($urandom_range(0, 4095));
         end else if (r < 85) begin
            v = longint'($urandom_range(1, 4095)) << $urandom_range(0, 19);
         end else if (r < 95) begin
            v = 64'($urandom_range(0, 65535));
         end else begin
            v = 64'($urandom_range(0, 2));
         end
         numbers_q.push_back(v[NW-1:0]);
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (numbers_q.size() != 0 || taken != offered || factors_q.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
